@@ rtl/signed_int_to_decimal_ascii_assert.svh @@
// Assertion macros for the signed integer to decimal text converter.
// Used by signed_int_to_decimal_ascii.sv; expects i_clk and i_rst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SIDA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sida assertion failed");

// next-cycle implication, disabled in reset
`define SIDA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sida assertion failed");

`endif

@@ rtl/sida_pkg.sv @@
// Package for the signed integer to decimal text converter.
// Holds character codes, widths and the sequencer state type; no dependencies.
`default_nettype none

package sida_pkg;

    localparam int CHAR_W = 6;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_SKIP  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII text, bit-serial double-dabble conversion.
// Depends on sida_pkg and signed_int_to_decimal_ascii_assert.svh.
//
//  channel  | dir | tdata                         | tlast
//  s_axis   | in  | value [VALUE_WIDTH-1:0]       | -
//  m_axis   | out | text_char [5:0], zero pad     | is_last
//
// After acceptance the BCD register takes VALUE_WIDTH shift/add-3 steps, then the
// suppressed leading zeros are shifted out and the first character is picked, then
// the characters are sent one at a time (sign first). The next value is taken once
// the last character is loaded and the sequencer is back in idle.
// i_rst_n is synchronous, active low; it clears the sequencer and the output valid.
// A stalled output holds its character and pauses the sequencer in its sign and digit states.
`default_nettype none

module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [VALUE_WIDTH-1:0] value, rest zero pad
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [5:0] text_char, [7:6] zero pad
    output logic [OUT_TDATA_W-1:0]           m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int NDIG = (((VALUE_WIDTH - 1) * 30103) / 100000) + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W = $clog2(NDIG + 1);

    t_state                   r_state, n_state;
    logic [VALUE_WIDTH-1:0]   r_mag, n_mag;
    logic [BCD_W-1:0]         r_bcd, n_bcd;
    logic                     r_neg, n_neg;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [LEFT_W-1:0]        r_left, n_left;
    logic                     r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]        r_char, n_char;
    logic                     r_last, n_last;

    logic [BCD_W-1:0]         w_adj;
    logic [3:0]               w_top;
    logic                     w_slot;
    logic                     w_in_acc;
    logic [VALUE_WIDTH-1:0]   w_raw;

    assign w_raw    = s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_top    = r_bcd[BCD_W-1 -: 4];
    assign w_slot   = !r_ovalid || m_axis_tready;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(OUT_TDATA_W - CHAR_W)'(0), r_char};
    assign m_axis_tlast  = r_last;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_neg   = w_raw[VALUE_WIDTH-1];
                    n_mag   = w_raw[VALUE_WIDTH-1] ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_WIDTH);
                    n_left  = LEFT_W'(NDIG);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == 4'd0 && r_left > LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - LEFT_W'(1);
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_ZERO + CHAR_W'(w_top);
                    n_last   = (r_left == LEFT_W'(1));
                    n_bcd    = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left   = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

`include "signed_int_to_decimal_ascii_assert.svh"

    `SIDA_ASSERT_NXT(a_accept_starts_conv, w_in_acc, r_state == S_CONV)
    `SIDA_ASSERT_IMP(a_sign_only_negative, r_state == S_SIGN, r_neg)
    `SIDA_ASSERT_NXT(a_final_digit_last, r_state == S_DIGIT && w_slot && r_left == LEFT_W'(1),
        r_ovalid && r_last && r_state == S_IDLE)
    `SIDA_ASSERT_IMP(a_char_range, r_ovalid,
        r_char == CHAR_MINUS || (r_char >= CHAR_ZERO && r_char <= CHAR_NINE))

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for signed_int_to_decimal_ascii: drives signed 32-bit values and checks
// the decimal characters and the tlast marker. The expected text is computed here.
// Depends on sida_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module tb;
    import sida_pkg::*;

    localparam int VALUE_W  = 32;
    localparam int IN_W     = ((VALUE_W + 7) / 8) * 8;
    localparam int IDLE_PCT = 9;
    localparam int LATENCY  = 60;
    localparam int LIMIT    = 300000;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              is_last;
    } t_text_char;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] value
    logic [IN_W-1:0]        s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [5:0] text_char, [7:6] zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    t_text_char             text_q[$];
    t_text_char             expected_char;
    int                     errors = 0;
    bit                     steady = 1'b0;
    int                     cycles = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits[$];
        t_text_char         c;
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (value[VALUE_W-1]) begin
            c.text_char = CHAR_MINUS;
            c.is_last   = 1'b0;
            text_q.push_back(c);
        end
        while (digits.size() != 0) begin
            c.text_char = CHAR_ZERO + CHAR_W'(digits.pop_front());
            c.is_last   = (digits.size() == 0);
            text_q.push_back(c);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned span;
        logic [VALUE_W-1:0] v;
        int n;
        span = 1;
        case ($urandom_range(3))
            0: v = $urandom;
            1: begin
                n = $urandom_range(1, 10);
                repeat (n) span = span * 10;
                v = VALUE_W'({$urandom, $urandom} % span);
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                n = $urandom_range(0, 9);
                repeat (n) span = span * 10;
                v = VALUE_W'(span) + VALUE_W'($urandom_range(2)) - 1'b1;
                if ($urandom_range(1)) v = -v;
            end
            default: begin
                if ($urandom_range(1)) v = 32'h8000_0000 + $urandom_range(20);
                else v = 32'h7fff_ffff - $urandom_range(20);
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(value);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_text(value);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [VALUE_W-1:0] values[$];
        values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                   32'd999999999, -32'sd999999999, 32'h5555_5555, 32'haaaa_aaaa,
                   32'd1234567890, -32'sd1234567890, 32'd7, -32'sd5, 32'd4294967295,
                   32'd1000000001, -32'sd1000000000};
        foreach (values[i]) send_value(values[i]);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    task automatic test_steady(input int count);
        steady = 1'b1;
        repeat (count) send_value(random_value());
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (text_q.size() == 0) begin
                $display("%0t: unexpected char: expected none, actual tdata=%h tlast=%b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                expected_char = text_q.pop_front();
                if (m_axis_tdata !== {{(OUT_TDATA_W-CHAR_W){1'b0}}, expected_char.text_char})
                begin
                    $display("%0t: text_char mismatch: expected %h, actual %h",
                             $time, expected_char.text_char, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== expected_char.is_last) begin
                    $display("%0t: is_last mismatch: expected %b, actual %b",
                             $time, expected_char.is_last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(200);
        wait_drained();
        test_steady(100);
        test_random(160);
        wait_drained();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
